[design/xoshiro128_ranged_random_macros.svh]
// assertion helpers used by the asserting file
`ifndef XOSHIRO128_RANGED_RANDOM_MACROS_SVH
`define XOSHIRO128_RANGED_RANDOM_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define XRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define XRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/xrr_pkg.sv]
`timescale 1ns / 1ps

package xrr_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_RESEED = 1'b1;

  // generator state after reset, same as seeding with one
  localparam logic [WORD_W-1:0] RST_W0 = 32'h0000_0001;
  localparam logic [WORD_W-1:0] RST_W1 = 32'h0000_0001;
  localparam logic [WORD_W-1:0] RST_W2 = 32'h0200_0001;
  localparam logic [WORD_W-1:0] RST_W3 = 32'h0200_0001;

  typedef struct packed {
    logic                     kind;
    logic signed [WORD_W-1:0] seed;
    logic signed [WORD_W-1:0] range_low;
    logic signed [WORD_W-1:0] range_high;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              is_fraction;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic advance;
  } gen_ctl_t;

endpackage

[design/xrr_gen.sv]
`timescale 1ns / 1ps

module xrr_gen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  xrr_pkg::gen_ctl_t         ctl,
  input  logic [xrr_pkg::WORD_W-1:0] seed,
  output logic [xrr_pkg::WORD_W-1:0] word
);
  import xrr_pkg::*;

  logic [WORD_W-1:0] w0_r, w1_r, w2_r, w3_r;
  logic [WORD_W-1:0] w0_nxt, w1_nxt, w2_nxt, w3_nxt;
  logic [WORD_W-1:0] s1, s2, s3;
  logic [WORD_W-1:0] mul5, rot7;
  logic [WORD_W-1:0] a2, a3, a1, a0, t9;

  // seeding by arithmetic right and plain left xorshifts
  assign s1 = seed ^ WORD_W'($signed(seed) >>> 12);
  assign s2 = s1 ^ (s1 << 25);
  assign s3 = s2 ^ WORD_W'($signed(s2) >>> 27);

  // scrambled output, constant multiplies as shift and add
  assign mul5 = w1_r + (w1_r << 2);
  assign rot7 = {mul5[WORD_W-8:0], mul5[WORD_W-1:WORD_W-7]};
  assign word = rot7 + (rot7 << 3);

  assign t9 = w1_r << 9;
  assign a2 = w2_r ^ w0_r;
  assign a3 = w3_r ^ w1_r;
  assign a1 = w1_r ^ a2;
  assign a0 = w0_r ^ a3;

  always_comb begin
    w0_nxt = w0_r;
    w1_nxt = w1_r;
    w2_nxt = w2_r;
    w3_nxt = w3_r;
    if (ctl.load) begin
      w0_nxt = seed;
      w1_nxt = s1;
      w2_nxt = s2;
      w3_nxt = s3;
    end else if (ctl.advance) begin
      w0_nxt = a0;
      w1_nxt = a1;
      w2_nxt = a2 ^ t9;
      w3_nxt = {a3[WORD_W-12:0], a3[WORD_W-1:WORD_W-11]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r <= RST_W0;
      w1_r <= RST_W1;
      w2_r <= RST_W2;
      w3_r <= RST_W3;
    end else begin
      w0_r <= w0_nxt;
      w1_r <= w1_nxt;
      w2_r <= w2_nxt;
      w3_r <= w3_nxt;
    end
  end

endmodule

[design/xrr_div.sv]
`timescale 1ns / 1ps

module xrr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [xrr_pkg::WORD_W-1:0] dividend,
  input  logic [xrr_pkg::WORD_W-1:0] divisor,
  output logic                       done,
  output logic [xrr_pkg::WORD_W-1:0] remainder
);
  import xrr_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] dvd_r, dvd_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              fits;

  // one restoring step per cycle
  assign trial = {rem_r, dvd_r[WORD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      rem_nxt = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[design/xoshiro128_ranged_random.sv]
`timescale 1ns / 1ps
// xoshiro128** generator with optional range reduction of each drawn word.
// input channel: in_valid / in_stall / in_word, word taken when valid and not stall.
// result channel: out_valid / out_stall / out_word, one result per draw word.
// a reseed word loads the four state words in the accept cycle and gives no result;
// the next word can be taken in the following cycle.
// a draw word advances the state in its accept cycle. with both bounds at -1 the
// raw word is flagged as a 0.32 fraction; other bounds outside the two ranged
// cases give the raw word. those results are registered at acceptance and move
// from S_DONE into the output register.
// ranged draws run a serial restoring divider, one remainder bit per cycle.
// only one draw is in flight; in_stall is high until its result sits in the
// output register, which may hold while a new word is taken.
// if the receiver stalls, the result holds in the output register and a
// finished draw waits behind it.
// synchronous active-low reset leaves the state as if seeded with one and
// clears both channels.
module xoshiro128_ranged_random (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  xrr_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output xrr_pkg::out_word_t  out_word
);
  import xrr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;
  logic [WORD_W-1:0] base_r, base_nxt;
  logic              frac_r, frac_nxt;

  gen_ctl_t          gen_ctl;
  logic [WORD_W-1:0] gen_word;
  logic              div_start;
  logic [WORD_W-1:0] div_divisor;
  logic              div_done;
  logic [WORD_W-1:0] div_rem;

  logic              in_take;
  logic              both_absent, span_ok, upper_only;
  logic [WORD_W-1:0] span;

  xrr_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (gen_ctl),
    .seed  (in_word.seed),
    .word  (gen_word)
  );

  xrr_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (gen_word),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // bound decode
  assign both_absent = (in_word.range_low == '1) && (in_word.range_high == '1);
  assign span_ok     = !in_word.range_low[WORD_W-1] &&
                       (in_word.range_high > in_word.range_low);
  assign upper_only  = !in_word.range_low[WORD_W-1] && (in_word.range_low != '0) &&
                       (in_word.range_high == '1);
  assign span        = $unsigned(in_word.range_high) - $unsigned(in_word.range_low)
                       + WORD_W'(1);
  assign div_divisor = span_ok ? span : $unsigned(in_word.range_low);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    res_nxt       = res_r;
    base_nxt      = base_r;
    frac_nxt      = frac_r;
    gen_ctl       = '0;
    div_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_word.kind == KIND_RESEED) begin
            gen_ctl.load = 1'b1;
          end else begin
            gen_ctl.advance = 1'b1;
            frac_nxt        = both_absent;
            base_nxt        = span_ok ? $unsigned(in_word.range_low) : WORD_W'(1);
            if (span_ok || upper_only) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end else begin
              res_nxt   = gen_word;
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = base_r + div_rem;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.value       = res_r;
          out_word_nxt.is_fraction = frac_r;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
    res_r      <= res_nxt;
    base_r     <= base_nxt;
    frac_r     <= frac_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`include "xoshiro128_ranged_random_macros.svh"

  `XRR_ASSERT_NOW(a_div_done_in_div, div_done, state_r == S_DIV, "divider finished outside a ranged draw")
  `XRR_ASSERT_NEXT(a_ranged_enters_div, div_start, state_r == S_DIV && !div_done, "ranged draw did not start dividing")
  `XRR_ASSERT_NEXT(a_done_delivers, state_r == S_DONE && !out_valid_r, out_valid_r && state_r == S_IDLE, "finished draw not moved to output")

endmodule
